### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/les_pkg.sv
package les_pkg;

    localparam int FRAC_BITS     = 20;
    localparam int WORD_BITS     = 32;
    localparam int PROD_BITS     = 2 * WORD_BITS;
    localparam int TIME_BITS     = 48;
    localparam int FIELD_BITS    = 32;
    localparam int STEP_BITS     = 31;
    localparam int EXT_BITS      = (WORD_BITS > FIELD_BITS) ? WORD_BITS + 1 : FIELD_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef logic signed [WORD_BITS-1:0]  word_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic        [TIME_BITS-1:0]  time_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic signed [EXT_BITS-1:0]   ext_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam time_t TMAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SIGMA = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RHO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETA  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP  = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Reset coefficients: 10, 28, 8/3 and 0.01, rounded to the nearest step.
    localparam longint SIGMA_RST = longint'(10) <<< FRAC_BITS;
    localparam longint RHO_RST   = longint'(28) <<< FRAC_BITS;
    localparam longint BETA_RST  = ((longint'(16) <<< FRAC_BITS) + 3) / 6;
    localparam longint STEP_RST  = ((longint'(1) <<< FRAC_BITS) + 50) / 100;

    typedef struct packed {
        word_t word;
        logic  clip;
    } sat_t;

    typedef struct packed {
        logic   kind;
        field_t load_x;
        field_t load_y;
        field_t load_z;
    } les_cmd_t;

    typedef struct packed {
        time_t  elapsed;
        field_t point_x;
        field_t point_y;
        field_t point_z;
        logic   clipped;
    } les_rsp_t;

    function automatic word_t clamp_long(longint v);
        word_t r;
        if (v > longint'(WMAX)) begin
            r = WMAX;
        end else if (v < longint'(WMIN)) begin
            r = WMIN;
        end else begin
            r = word_t'(v);
        end
        return r;
    endfunction

    function automatic sat_t sat_sum(logic signed [WORD_BITS:0] s);
        sat_t r;
        r.clip = (s[WORD_BITS] != s[WORD_BITS-1]);
        if (r.clip) begin
            r.word = s[WORD_BITS] ? WMIN : WMAX;
        end else begin
            r.word = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic sat_t clamp_field(field_t v);
        ext_t e;
        sat_t r;
        e = EXT_BITS'(v);
        r.clip = 1'b0;
        if (e > EXT_BITS'(WMAX)) begin
            r.word = WMAX;
            r.clip = 1'b1;
        end else if (e < EXT_BITS'(WMIN)) begin
            r.word = WMIN;
            r.clip = 1'b1;
        end else begin
            r.word = e[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic word_t clamp_step(logic [STEP_BITS-1:0] v);
        ext_t  e;
        word_t r;
        e = $signed(EXT_BITS'(v));
        if (e > EXT_BITS'(WMAX)) begin
            r = WMAX;
        end else begin
            r = e[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic field_t to_field(word_t w);
        ext_t e;
        e = EXT_BITS'(w);
        return e[FIELD_BITS-1:0];
    endfunction

    // Scales an exact product back to the word format, rounding half away
    // from zero, and saturates on the magnitude.
    function automatic sat_t round_prod(prod_t p, logic neg);
        logic [PROD_BITS-1:0] mag;
        logic [PROD_BITS-1:0] q;
        logic [PROD_BITS-1:0] lim;
        logic [WORD_BITS-1:0] qw;
        sat_t                 r;
        mag    = neg ? unsigned'(-p) : unsigned'(p);
        q      = (mag + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim    = {{WORD_BITS{1'b0}}, WMAX} + PROD_BITS'(neg);
        r.clip = (q > lim);
        if (r.clip) begin
            q = lim;
        end
        qw     = q[WORD_BITS-1:0];
        r.word = neg ? -$signed(qw) : $signed(qw);
        return r;
    endfunction

endpackage

### rtl/les_cmd_if.sv
interface les_cmd_if import les_pkg::*; ();

    logic     valid;
    logic     ready;
    les_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

### rtl/les_rsp_if.sv
interface les_rsp_if import les_pkg::*; ();

    logic     valid;
    logic     ready;
    les_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

### rtl/lorenz_euler_stepper_unit.sv
// Forward-Euler stepper for the Lorenz system in signed Q12.20 fixed point.
// A load transfer sets the point and clears the elapsed time; a step transfer
// advances the point by one Euler step with the configured sigma, rho, beta and
// step size. Every command transfer yields exactly one result transfer. A step
// runs through the states PREP, M1 to M7, RND and WB, and a load goes
// straight to WB. The block takes no new command until WB completes, and the
// command side is ready again in the same cycle that the result is offered.
// A result that is still waiting holds the next finished item in write-back
// until it is taken. The step time is set by the single shared 32 by 32
// multiplier, which forms the seven products one per cycle, each rounded and
// saturated in the following cycle. Configuration writes are expected only while
// the block is idle. A result that saturates raises the clipped flag.
`include "assert_macros.svh"

module lorenz_euler_stepper_unit import les_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    les_cmd_if.sink                  cmd,
    les_rsp_if.source                rsp,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_M4   = 4'd5;
    localparam logic [3:0] ST_M5   = 4'd6;
    localparam logic [3:0] ST_M6   = 4'd7;
    localparam logic [3:0] ST_M7   = 4'd8;
    localparam logic [3:0] ST_RND  = 4'd9;
    localparam logic [3:0] ST_WB   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    les_rsp_t   out_reg, out_next;

    word_t sigma_reg, sigma_next;
    word_t rho_reg, rho_next;
    word_t beta_reg, beta_next;
    word_t step_reg, step_next;
    word_t pos_x_reg, pos_x_next;
    word_t pos_y_reg, pos_y_next;
    word_t pos_z_reg, pos_z_next;
    time_t sim_time_reg, sim_time_next;

    logic  kind_reg, kind_next;
    logic  clip_reg, clip_next;
    word_t d1_reg, d1_next;
    word_t d2_reg, d2_next;
    word_t xy_reg, xy_next;
    word_t m1_reg, m1_next;
    word_t m3_reg, m3_next;
    word_t bz_reg, bz_next;
    word_t e2_reg, e2_next;
    word_t e3_reg, e3_next;
    word_t dx_reg, dx_next;
    word_t dy_reg, dy_next;
    word_t dz_reg, dz_next;
    prod_t prod_reg, prod_next;
    logic  neg_reg, neg_next;

    word_t op_a;
    word_t op_b;
    sat_t  rnd;
    sat_t  s_a;
    sat_t  s_b;
    sat_t  s_c;
    sat_t  s_cfg;
    logic [TIME_BITS:0] t_sum;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        case (state_reg)
            ST_M1:
            begin
                op_a = pos_x_reg;
                op_b = pos_y_reg;
            end
            ST_M2:
            begin
                op_a = sigma_reg;
                op_b = d1_reg;
            end
            ST_M3:
            begin
                op_a = pos_x_reg;
                op_b = d2_reg;
            end
            ST_M4:
            begin
                op_a = beta_reg;
                op_b = pos_z_reg;
            end
            ST_M5:
            begin
                op_a = m1_reg;
                op_b = step_reg;
            end
            ST_M6:
            begin
                op_a = e2_reg;
                op_b = step_reg;
            end
            ST_M7:
            begin
                op_a = e3_reg;
                op_b = step_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign neg_next  = op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
    assign rnd       = round_prod(prod_reg, neg_reg);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sigma_next     = sigma_reg;
        rho_next       = rho_reg;
        beta_next      = beta_reg;
        step_next      = step_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        sim_time_next  = sim_time_reg;
        kind_next      = kind_reg;
        clip_next      = clip_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        xy_next        = xy_reg;
        m1_next        = m1_reg;
        m3_next        = m3_reg;
        bz_next        = bz_reg;
        e2_next        = e2_reg;
        e3_next        = e3_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        s_a            = '0;
        s_b            = '0;
        s_c            = '0;
        t_sum          = '0;
        s_cfg          = clamp_field(cfg_data);

        if (out_valid_reg && rsp.ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                CFG_SIGMA: sigma_next = s_cfg.word;
                CFG_RHO:   rho_next   = s_cfg.word;
                CFG_BETA:  beta_next  = s_cfg.word;
                CFG_STEP:  step_next  = clamp_step(cfg_data[STEP_BITS-1:0]);
                default:   step_next  = step_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid) begin
                    kind_next = cmd.data.kind;
                    if (cmd.data.kind == KIND_STEP) begin
                        clip_next  = 1'b0;
                        state_next = ST_PREP;
                    end else begin
                        s_a        = clamp_field(cmd.data.load_x);
                        s_b        = clamp_field(cmd.data.load_y);
                        s_c        = clamp_field(cmd.data.load_z);
                        dx_next    = s_a.word;
                        dy_next    = s_b.word;
                        dz_next    = s_c.word;
                        clip_next  = s_a.clip | s_b.clip | s_c.clip;
                        state_next = ST_WB;
                    end
                end
            end
            ST_PREP:
            begin
                s_a        = sat_sum({pos_y_reg[WORD_BITS-1], pos_y_reg}
                                     - {pos_x_reg[WORD_BITS-1], pos_x_reg});
                s_b        = sat_sum({rho_reg[WORD_BITS-1], rho_reg}
                                     - {pos_z_reg[WORD_BITS-1], pos_z_reg});
                d1_next    = s_a.word;
                d2_next    = s_b.word;
                clip_next  = clip_reg | s_a.clip | s_b.clip;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                state_next = ST_M2;
            end
            ST_M2:
            begin
                xy_next    = rnd.word;
                clip_next  = clip_reg | rnd.clip;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                m1_next    = rnd.word;
                clip_next  = clip_reg | rnd.clip;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                m3_next    = rnd.word;
                clip_next  = clip_reg | rnd.clip;
                state_next = ST_M5;
            end
            ST_M5:
            begin
                s_a        = sat_sum({m3_reg[WORD_BITS-1], m3_reg}
                                     - {pos_y_reg[WORD_BITS-1], pos_y_reg});
                bz_next    = rnd.word;
                e2_next    = s_a.word;
                clip_next  = clip_reg | rnd.clip | s_a.clip;
                state_next = ST_M6;
            end
            ST_M6:
            begin
                s_a        = sat_sum({xy_reg[WORD_BITS-1], xy_reg}
                                     - {bz_reg[WORD_BITS-1], bz_reg});
                dx_next    = rnd.word;
                e3_next    = s_a.word;
                clip_next  = clip_reg | rnd.clip | s_a.clip;
                state_next = ST_M7;
            end
            ST_M7:
            begin
                dy_next    = rnd.word;
                clip_next  = clip_reg | rnd.clip;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                dz_next    = rnd.word;
                clip_next  = clip_reg | rnd.clip;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (!out_valid_reg || rsp.ready) begin
                    if (kind_reg == KIND_STEP) begin
                        s_a   = sat_sum({pos_x_reg[WORD_BITS-1], pos_x_reg}
                                        + {dx_reg[WORD_BITS-1], dx_reg});
                        s_b   = sat_sum({pos_y_reg[WORD_BITS-1], pos_y_reg}
                                        + {dy_reg[WORD_BITS-1], dy_reg});
                        s_c   = sat_sum({pos_z_reg[WORD_BITS-1], pos_z_reg}
                                        + {dz_reg[WORD_BITS-1], dz_reg});
                        t_sum = {1'b0, sim_time_reg}
                                + {{(TIME_BITS + 1 - WORD_BITS){1'b0}}, step_reg};
                        pos_x_next = s_a.word;
                        pos_y_next = s_b.word;
                        pos_z_next = s_c.word;
                        if (t_sum[TIME_BITS]) begin
                            sim_time_next = TMAX;
                        end else begin
                            sim_time_next = t_sum[TIME_BITS-1:0];
                        end
                        clip_next = clip_reg | s_a.clip | s_b.clip | s_c.clip
                                    | t_sum[TIME_BITS];
                    end else begin
                        pos_x_next    = dx_reg;
                        pos_y_next    = dy_reg;
                        pos_z_next    = dz_reg;
                        sim_time_next = '0;
                    end
                    out_next.elapsed = sim_time_next;
                    out_next.point_x = to_field(pos_x_next);
                    out_next.point_y = to_field(pos_y_next);
                    out_next.point_z = to_field(pos_z_next);
                    out_next.clipped = clip_next;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sigma_reg     <= clamp_long(SIGMA_RST);
            rho_reg       <= clamp_long(RHO_RST);
            beta_reg      <= clamp_long(BETA_RST);
            step_reg      <= clamp_long(STEP_RST);
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            sim_time_reg  <= '0;
            kind_reg      <= KIND_LOAD;
            clip_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sigma_reg     <= sigma_next;
            rho_reg       <= rho_next;
            beta_reg      <= beta_next;
            step_reg      <= step_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            sim_time_reg  <= sim_time_next;
            kind_reg      <= kind_next;
            clip_reg      <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        xy_reg   <= xy_next;
        m1_reg   <= m1_next;
        m3_reg   <= m3_next;
        bz_reg   <= bz_next;
        e2_reg   <= e2_next;
        e3_reg   <= e3_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    `CHECK_NEXT(a_step_starts, cmd.valid && cmd.ready && cmd.data.kind == KIND_STEP,
                state_reg == ST_PREP, "step transfer did not start the sequence")
    `CHECK_NEXT(a_load_to_wb, cmd.valid && cmd.ready && cmd.data.kind == KIND_LOAD,
                state_reg == ST_WB, "load transfer did not go to write-back")
    `CHECK_NOW(a_rsp_from_wb, $rose(rsp.valid), $past(state_reg) == ST_WB,
               "result offered without a write-back")
    `CHECK_NEXT(a_wb_done, state_reg == ST_WB && (!rsp.valid || rsp.ready),
                state_reg == ST_IDLE && rsp.valid, "write-back did not complete")

endmodule
